### rtl/window_template_match_top_defines.svh
// Assertion macros for the window template matcher.
// Included by the modules that carry assertions; expects clk_i and rst_ni in scope.
`ifndef WINDOW_TEMPLATE_MATCH_TOP_DEFINES_SVH
`define WINDOW_TEMPLATE_MATCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define WTM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("window_template_match: assertion failed");
`define WTM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("window_template_match: assertion failed during reset");
`else
`define WTM_ASSERT(label, prop)
`define WTM_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/wtm_pkg.sv
// Shared types and constants of the window template matcher.
// No dependencies; used by wtm_hist, the top module and the testbench.
`default_nettype none
package wtm_pkg;

  // input operations
  typedef enum logic [1:0] {
    OP_WR_IMG = 2'd0,
    OP_WR_PAT = 2'd1,
    OP_EVAL   = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [2:0] CFG_IMG_W    = 3'd0;
  localparam logic [2:0] CFG_IMG_H    = 3'd1;
  localparam logic [2:0] CFG_PSIZE    = 3'd2;
  localparam logic [2:0] CFG_PIX_LIM  = 3'd3;
  localparam logic [2:0] CFG_MED_LIM  = 3'd4;

  // configuration reset values
  localparam logic [6:0] RST_IMG_W   = 7'd64;
  localparam logic [6:0] RST_IMG_H   = 7'd64;
  localparam logic [4:0] RST_PSIZE   = 5'd4;
  localparam logic [7:0] RST_PIX_LIM = 8'd10;
  localparam logic [7:0] RST_MED_LIM = 8'd3;

  localparam int unsigned GOOD_W = 16;

  // histogram control from the sequencer
  typedef struct packed {
    logic rd_en;      // read one count (increment or scan)
    logic inc_en;     // write back the count read last cycle plus one
    logic acc_en;     // fold the count read last cycle into the rank search
    logic wz_en;      // zero one count
    logic scan_init;  // restart the rank search
  } hist_ctl_t;

endpackage
`default_nettype wire

### rtl/wtm_hist.sv
// Histogram memory with increment and rank search for the template matcher.
// Depends on wtm_pkg for the control struct.
`default_nettype none
module wtm_hist #(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned CNT_W      = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire wtm_pkg::hist_ctl_t    ctl_i,
  input  wire logic [PIXEL_BITS-1:0] rd_addr_i,
  input  wire logic [PIXEL_BITS-1:0] wz_addr_i,
  input  wire logic [CNT_W-1:0]      k0_i,
  input  wire logic [CNT_W-1:0]      k1_i,
  output logic      [PIXEL_BITS:0]   dmed_o
);
  localparam int unsigned LEVELS = 1 << PIXEL_BITS;

  logic [CNT_W-1:0]      mem [LEVELS];
  logic [CNT_W-1:0]      rdata_q;
  logic [PIXEL_BITS-1:0] inc_addr_q;
  logic [CNT_W-1:0]      seen_q, seen_d;
  logic [PIXEL_BITS-1:0] r0_q, r1_q;
  logic                  got0_q, got1_q;

  // count memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.inc_en) begin
      mem[inc_addr_q] <= rdata_q + CNT_W'(1);
    end else if (ctl_i.wz_en) begin
      mem[wz_addr_i] <= '0;
    end
    if (ctl_i.rd_en) begin
      rdata_q    <= mem[rd_addr_i];
      inc_addr_q <= rd_addr_i;
    end
  end

  assign seen_d = seen_q + rdata_q;

  // walk the levels upward and catch the first level whose running count passes each rank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      got0_q <= 1'b0;
      got1_q <= 1'b0;
      r0_q   <= '1;
      r1_q   <= '1;
    end else if (ctl_i.scan_init) begin
      seen_q <= '0;
      got0_q <= 1'b0;
      got1_q <= 1'b0;
      r0_q   <= '1;
      r1_q   <= '1;
    end else if (ctl_i.acc_en) begin
      seen_q <= seen_d;
      if (!got0_q && seen_d > k0_i) begin
        got0_q <= 1'b1;
        r0_q   <= wz_addr_i;
      end
      if (!got1_q && seen_d > k1_i) begin
        got1_q <= 1'b1;
        r1_q   <= wz_addr_i;
      end
    end
  end

  assign dmed_o = {1'b0, r0_q} + {1'b0, r1_q};
endmodule
`default_nettype wire

### rtl/wtm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on the assertion macro header.
`default_nettype none
`include "window_template_match_top_defines.svh"
module wtm_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W:0]   rem_q, rem_sh, rem_d;
  logic [DEN_W-1:0] den_q;
  logic             qbit;

  // shift in one dividend bit and try one subtract
  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    qbit   = rem_sh >= {1'b0, den_q};
    rem_d  = qbit ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits replace dividend bits as they shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

  `WTM_ASSERT(a_div_no_restart, busy_q |-> !start_i)
  `WTM_ASSERT(a_div_done_after_busy, done_q |-> $past(busy_q))
  `WTM_ASSERT(a_div_rem_below_den, busy_q && !$rose(busy_q) |-> rem_q < {1'b0, den_q})
endmodule
`default_nettype wire

### rtl/window_template_match_top.sv
// Window template matcher: image and pattern stores, walk sequencer and result register.
// Depends on wtm_pkg, wtm_hist, wtm_div and the assertion macro header.
//
// Image and pattern pixel writes, rejected coordinates and the unused operation
// code are answered straight from the idle state. An evaluation walks the p x p
// window pixel by pixel (store read, then histogram read-modify-write), scans both
// histograms over all 2^PIXEL_BITS levels, and, on a match, runs the bit-serial
// divider; the input is stalled for that whole time. After reset the histogram
// memories are cleared level by level before the first item is taken;
// configuration writes are taken throughout. A finished result waits in the output
// register; while it is held off, the input is stalled as well.
`default_nettype none
`include "window_template_match_top_defines.svh"
module window_template_match_top #(
  parameter int unsigned MAX_IMAGE_WIDTH  = 64,
  parameter int unsigned MAX_IMAGE_HEIGHT = 64,
  parameter int unsigned MAX_PATTERN_SIZE = 16,
  parameter int unsigned PIXEL_BITS       = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_operation_i,
  input  wire logic [5:0]  in_row_i,
  input  wire logic [5:0]  in_column_i,
  input  wire logic [7:0]  in_pixel_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_status_o,
  output logic             out_matched_o,
  output logic             out_pixel_condition_ok_o,
  output logic             out_median_condition_ok_o,
  output logic [15:0]      out_goodness_o,
  output logic [5:0]       out_window_x_o,
  output logic [5:0]       out_window_y_o
);
  localparam int unsigned XW     = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
  localparam int unsigned YW     = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1;
  localparam int unsigned PW     = (MAX_PATTERN_SIZE > 1) ? $clog2(MAX_PATTERN_SIZE) : 1;
  localparam int unsigned LEVELS = 1 << PIXEL_BITS;
  localparam int unsigned N_W    = $clog2(MAX_PATTERN_SIZE * MAX_PATTERN_SIZE + 1);
  localparam int unsigned SUM_W  = PIXEL_BITS + N_W;
  localparam int unsigned NUM_W  = SUM_W + 8;
  localparam int unsigned CMP_W  =
      $clog2(MAX_IMAGE_WIDTH + MAX_IMAGE_HEIGHT + MAX_PATTERN_SIZE + 128) + 1;
  localparam int unsigned DL_W   = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;
  localparam int unsigned MW     = (PIXEL_BITS + 1 > 9) ? PIXEL_BITS + 1 : 9;
  localparam int unsigned QX_W   = (NUM_W > wtm_pkg::GOOD_W) ? NUM_W : wtm_pkg::GOOD_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_ACC   = 9'b000001000,
    S_INC   = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_MED   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // configuration registers
  logic [6:0] img_w_q, img_h_q;
  logic [4:0] psize_q;
  logic [7:0] pix_lim_q, med_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= wtm_pkg::RST_IMG_W;
      img_h_q   <= wtm_pkg::RST_IMG_H;
      psize_q   <= wtm_pkg::RST_PSIZE;
      pix_lim_q <= wtm_pkg::RST_PIX_LIM;
      med_lim_q <= wtm_pkg::RST_MED_LIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtm_pkg::CFG_IMG_W:   img_w_q   <= cfg_wdata_i[6:0];
        wtm_pkg::CFG_IMG_H:   img_h_q   <= cfg_wdata_i[6:0];
        wtm_pkg::CFG_PSIZE:   psize_q   <= cfg_wdata_i[4:0];
        wtm_pkg::CFG_PIX_LIM: pix_lim_q <= cfg_wdata_i;
        wtm_pkg::CFG_MED_LIM: med_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp sizes: zero acts as one, above the maximum acts as the maximum
  logic [CMP_W-1:0] w_c, h_c, p_c, p_m1;
  always_comb begin
    if (img_w_q == '0) w_c = CMP_W'(1);
    else if (CMP_W'(img_w_q) > CMP_W'(MAX_IMAGE_WIDTH)) w_c = CMP_W'(MAX_IMAGE_WIDTH);
    else w_c = CMP_W'(img_w_q);
    if (img_h_q == '0) h_c = CMP_W'(1);
    else if (CMP_W'(img_h_q) > CMP_W'(MAX_IMAGE_HEIGHT)) h_c = CMP_W'(MAX_IMAGE_HEIGHT);
    else h_c = CMP_W'(img_h_q);
    if (psize_q == '0) p_c = CMP_W'(1);
    else if (CMP_W'(psize_q) > CMP_W'(MAX_PATTERN_SIZE)) p_c = CMP_W'(MAX_PATTERN_SIZE);
    else p_c = CMP_W'(psize_q);
    p_m1 = p_c - CMP_W'(1);
  end

  // sequencer and walk registers
  state_e               st_q, st_d;
  logic [PIXEL_BITS:0]  cnt_q;
  logic [PIXEL_BITS-1:0] prev_q;
  logic [PW-1:0]        i_q, j_q;
  logic                 last_q;
  logic [5:0]           row_q, col_q;
  logic [SUM_W-1:0]     sum_q;
  logic [N_W-1:0]       n_q;
  logic                 pix_ok_q, med_ok_q;
  logic [wtm_pkg::GOOD_W-1:0] good_q;

  logic out_valid_q, out_free, in_acc;
  logic out_status_q, out_matched_q, out_pix_q, out_med_q;
  logic [wtm_pkg::GOOD_W-1:0] out_good_q;
  logic [5:0] out_x_q, out_y_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // coordinate checks on the incoming item
  logic [CMP_W-1:0] row_x, col_x;
  logic img_ok, pat_ok, win_ok;
  assign row_x  = CMP_W'(in_row_i);
  assign col_x  = CMP_W'(in_column_i);
  assign img_ok = (row_x < h_c) && (col_x < w_c);
  assign pat_ok = (row_x < p_c) && (col_x < p_c);
  assign win_ok = (col_x + p_c <= w_c) && (row_x + p_c <= h_c);

  // stores
  logic [PIXEL_BITS-1:0] img_mem [MAX_IMAGE_HEIGHT][MAX_IMAGE_WIDTH];
  logic [PIXEL_BITS-1:0] pat_mem [MAX_PATTERN_SIZE][MAX_PATTERN_SIZE];
  logic [PIXEL_BITS-1:0] img_rd_q, pat_rd_q, wpix;
  logic img_we, pat_we, st_re;
  logic [CMP_W-1:0] ry_x, rx_x;
  logic [CMP_W-1:0] i_x, j_x;

  assign wpix = PIXEL_BITS'(in_pixel_value_i);
  assign i_x  = CMP_W'(i_q);
  assign j_x  = CMP_W'(j_q);
  assign ry_x = CMP_W'(row_q) + i_x;
  assign rx_x = CMP_W'(col_q) + j_x;

  always_ff @(posedge clk_i) begin
    if (img_we) img_mem[row_x[YW-1:0]][col_x[XW-1:0]] <= wpix;
    if (pat_we) pat_mem[row_x[PW-1:0]][col_x[PW-1:0]] <= wpix;
    if (st_re) begin
      img_rd_q <= img_mem[ry_x[YW-1:0]][rx_x[XW-1:0]];
      pat_rd_q <= pat_mem[i_q][j_q];
    end
  end

  // shared absolute-difference unit
  logic [PIXEL_BITS-1:0] diff;
  logic                  diff_ok;
  assign diff    = (img_rd_q > pat_rd_q) ? img_rd_q - pat_rd_q : pat_rd_q - img_rd_q;
  assign diff_ok = DL_W'(diff) < DL_W'(pix_lim_q);

  // histograms and median compare
  wtm_pkg::hist_ctl_t    hctl;
  logic [PIXEL_BITS-1:0] hw_addr, hp_addr, wz_addr;
  logic [N_W-1:0]        k0, k1;
  logic [PIXEL_BITS:0]   dmed_w, dmed_p, md;
  logic                  med_ok;

  assign k1      = n_q >> 1;
  assign k0      = n_q[0] ? k1 : k1 - N_W'(1);
  assign wz_addr = (st_q == S_CLEAR) ? cnt_q[PIXEL_BITS-1:0] : prev_q;
  assign hw_addr = (st_q == S_ACC) ? img_rd_q : cnt_q[PIXEL_BITS-1:0];
  assign hp_addr = (st_q == S_ACC) ? pat_rd_q : cnt_q[PIXEL_BITS-1:0];
  assign md      = (dmed_w > dmed_p) ? dmed_w - dmed_p : dmed_p - dmed_w;
  assign med_ok  = MW'(md) < MW'({med_lim_q, 1'b0});

  wtm_hist #(.PIXEL_BITS(PIXEL_BITS), .CNT_W(N_W)) u_hist_win (
    .clk_i, .rst_ni, .ctl_i(hctl), .rd_addr_i(hw_addr), .wz_addr_i(wz_addr),
    .k0_i(k0), .k1_i(k1), .dmed_o(dmed_w)
  );
  wtm_hist #(.PIXEL_BITS(PIXEL_BITS), .CNT_W(N_W)) u_hist_pat (
    .clk_i, .rst_ni, .ctl_i(hctl), .rd_addr_i(hp_addr), .wz_addr_i(wz_addr),
    .k0_i(k0), .k1_i(k1), .dmed_o(dmed_p)
  );

  // divider for the mean difference
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quo;
  logic [QX_W-1:0]  quo_x;
  wtm_div #(.NUM_W(NUM_W), .DEN_W(N_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i({sum_q, 8'b0}), .den_i(n_q),
    .done_o(div_done), .quo_o(div_quo)
  );
  assign quo_x = QX_W'(div_quo);

  // sequencer control
  logic scan_last;
  assign scan_last = cnt_q == (PIXEL_BITS + 1)'(LEVELS);

  always_comb begin
    st_d      = st_q;
    img_we    = 1'b0;
    pat_we    = 1'b0;
    st_re     = 1'b0;
    hctl      = '0;
    div_start = 1'b0;
    case (st_q)
      S_CLEAR: begin
        hctl.wz_en = 1'b1;
        if (cnt_q == (PIXEL_BITS + 1)'(LEVELS - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_operation_i)
            wtm_pkg::OP_WR_IMG: img_we = img_ok;
            wtm_pkg::OP_WR_PAT: pat_we = pat_ok;
            wtm_pkg::OP_EVAL:   if (win_ok) st_d = S_RD;
            default: ;
          endcase
        end
      end
      S_RD: begin
        st_re = 1'b1;
        st_d  = S_ACC;
      end
      S_ACC: begin
        hctl.rd_en = 1'b1;
        st_d       = S_INC;
      end
      S_INC: begin
        hctl.inc_en = 1'b1;
        if (last_q) begin
          hctl.scan_init = 1'b1;
          st_d = S_SCAN;
        end else begin
          st_re = 1'b1;
          st_d  = S_ACC;
        end
      end
      S_SCAN: begin
        hctl.rd_en  = !scan_last;
        hctl.acc_en = cnt_q != '0;
        hctl.wz_en  = cnt_q != '0;
        if (scan_last) st_d = S_MED;
      end
      S_MED: begin
        if (pix_ok_q && med_ok) begin
          div_start = 1'b1;
          st_d = S_DIV;
        end else begin
          st_d = S_DONE;
        end
      end
      S_DIV: if (div_done) st_d = S_DONE;
      S_DONE: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLEAR;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == S_CLEAR || st_q == S_SCAN) cnt_q <= cnt_q + (PIXEL_BITS + 1)'(1);
      else cnt_q <= '0;
    end
  end

  // walk datapath: advance indices, accumulate, track conditions
  always_ff @(posedge clk_i) begin
    prev_q <= cnt_q[PIXEL_BITS-1:0];
    if (st_q == S_IDLE && in_acc) begin
      row_q    <= in_row_i;
      col_q    <= in_column_i;
      i_q      <= '0;
      j_q      <= '0;
      sum_q    <= '0;
      pix_ok_q <= 1'b1;
      med_ok_q <= 1'b0;
      good_q   <= '0;
      n_q      <= N_W'(p_c * p_c);
    end
    if (st_q == S_ACC) begin
      sum_q  <= sum_q + SUM_W'(diff);
      last_q <= (j_x == p_m1) && (i_x == p_m1);
      if (!diff_ok) pix_ok_q <= 1'b0;
      if (j_x == p_m1) begin
        j_q <= '0;
        i_q <= i_q + PW'(1);
      end else begin
        j_q <= j_q + PW'(1);
      end
    end
    if (st_q == S_MED) med_ok_q <= pix_ok_q && med_ok;
    if (div_done) begin
      good_q <= (quo_x > QX_W'({wtm_pkg::GOOD_W{1'b1}})) ? '1
                                                         : quo_x[wtm_pkg::GOOD_W-1:0];
    end
  end

  // result register: load on items answered from the idle state and at the end of an evaluation
  logic res_load_idle, res_load_done, res_status;
  assign res_load_idle = st_q == S_IDLE && in_acc &&
                         !(in_operation_i == wtm_pkg::OP_EVAL && win_ok);
  assign res_load_done = st_q == S_DONE && out_free;
  always_comb begin
    case (in_operation_i)
      wtm_pkg::OP_WR_IMG: res_status = !img_ok;
      wtm_pkg::OP_WR_PAT: res_status = !pat_ok;
      default:            res_status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load_idle || res_load_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load_idle) begin
      out_status_q  <= res_status;
      out_matched_q <= 1'b0;
      out_pix_q     <= 1'b0;
      out_med_q     <= 1'b0;
      out_good_q    <= '0;
      out_x_q       <= in_column_i;
      out_y_q       <= in_row_i;
    end else if (res_load_done) begin
      out_status_q  <= 1'b0;
      out_matched_q <= med_ok_q;
      out_pix_q     <= pix_ok_q;
      out_med_q     <= med_ok_q;
      out_good_q    <= med_ok_q ? good_q : '0;
      out_x_q       <= col_q;
      out_y_q       <= row_q;
    end
  end

  assign out_valid_o               = out_valid_q;
  assign out_status_o              = out_status_q;
  assign out_matched_o             = out_matched_q;
  assign out_pixel_condition_ok_o  = out_pix_q;
  assign out_median_condition_ok_o = out_med_q;
  assign out_goodness_o            = out_good_q;
  assign out_window_x_o            = out_x_q;
  assign out_window_y_o            = out_y_q;

  `WTM_ASSERT_ALWAYS(a_rst_clear, !rst_ni |=> (st_q == S_CLEAR) && !out_valid_o)
  `WTM_ASSERT(a_busy_stall, (st_q != S_IDLE) |-> in_stall_o)
  `WTM_ASSERT(a_div_in_div, div_done |-> (st_q == S_DIV))
  `WTM_ASSERT(a_match_flags, out_valid_o && out_matched_o |-> out_pixel_condition_ok_o && out_median_condition_ok_o && !out_status_o)
  `WTM_ASSERT(a_good_zero, out_valid_o && !out_matched_o |-> (out_goodness_o == '0))
endmodule
`default_nettype wire

### tb/window_template_match_top_test.sv
// Self-checking testbench for window_template_match_top: drives pixel writes and
// window evaluations, predicts each result and compares it field by field.
// Depends on wtm_pkg and the RTL of the block only.
`default_nettype none
module window_template_match_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  // image rows and columns below this are written before any evaluation
  localparam int unsigned FILL_SIZE = 16;

  typedef struct {
    logic        status;
    logic        matched;
    logic        pix_ok;
    logic        med_ok;
    logic [15:0] goodness;
    logic [5:0]  win_x;
    logic [5:0]  win_y;
  } match_result_t;

  // Shadow of the stores and registers, plus the queue of predicted results
  class match_scoreboard;
    logic [7:0]    img [64][64];
    logic [7:0]    pat [16][16];
    logic [7:0]    cfg [5];
    int unsigned   hist_win [256];
    int unsigned   hist_pat [256];
    match_result_t pending_q [$];
    int            errors;

    function new();
      cfg[wtm_pkg::CFG_IMG_W]   = 8'(wtm_pkg::RST_IMG_W);
      cfg[wtm_pkg::CFG_IMG_H]   = 8'(wtm_pkg::RST_IMG_H);
      cfg[wtm_pkg::CFG_PSIZE]   = 8'(wtm_pkg::RST_PSIZE);
      cfg[wtm_pkg::CFG_PIX_LIM] = wtm_pkg::RST_PIX_LIM;
      cfg[wtm_pkg::CFG_MED_LIM] = wtm_pkg::RST_MED_LIM;
      errors = 0;
    endfunction

    function int unsigned size_of(logic [2:0] idx, int unsigned maxv);
      int unsigned v;
      v = (idx == wtm_pkg::CFG_PSIZE) ? int'(cfg[idx][4:0]) : int'(cfg[idx][6:0]);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function int unsigned rank_level(bit from_win, int unsigned k);
      int unsigned seen;
      seen = 0;
      for (int v = 0; v < 256; v++) begin
        seen += from_win ? hist_win[v] : hist_pat[v];
        if (seen > k) return v;
      end
      return 255;
    endfunction

    function int unsigned doubled_median(bit from_win, int unsigned n);
      if (n % 2 == 1) return 2 * rank_level(from_win, n / 2);
      return rank_level(from_win, n / 2) + rank_level(from_win, n / 2 - 1);
    endfunction

    // Predict the result of one accepted transfer and update the shadow stores
    function void note_input(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                             logic [7:0] val);
      match_result_t r;
      int unsigned w, h, p, n, a, b, d, ma, mb, md;
      longint unsigned sum, good;
      w = size_of(wtm_pkg::CFG_IMG_W, 64);
      h = size_of(wtm_pkg::CFG_IMG_H, 64);
      p = size_of(wtm_pkg::CFG_PSIZE, 16);
      r = '{status: 1'b1, matched: 1'b0, pix_ok: 1'b0, med_ok: 1'b0,
            goodness: '0, win_x: col, win_y: row};
      case (op)
        wtm_pkg::OP_WR_IMG: begin
          if (row < h && col < w) begin
            img[row][col] = val;
            r.status = 1'b0;
          end
        end
        wtm_pkg::OP_WR_PAT: begin
          if (row < p && col < p) begin
            pat[row][col] = val;
            r.status = 1'b0;
          end
        end
        wtm_pkg::OP_EVAL: begin
          if (col + p <= w && row + p <= h) begin
            r.status = 1'b0;
            r.pix_ok = 1'b1;
            n = p * p;
            sum = 0;
            foreach (hist_win[v]) begin
              hist_win[v] = 0;
              hist_pat[v] = 0;
            end
            for (int i = 0; i < p; i++) begin
              for (int j = 0; j < p; j++) begin
                a = img[row + i][col + j];
                b = pat[i][j];
                d = (a > b) ? a - b : b - a;
                if (d >= cfg[wtm_pkg::CFG_PIX_LIM]) r.pix_ok = 1'b0;
                sum += d;
                hist_win[a]++;
                hist_pat[b]++;
              end
            end
            if (r.pix_ok) begin
              ma = doubled_median(1'b1, n);
              mb = doubled_median(1'b0, n);
              md = (ma > mb) ? ma - mb : mb - ma;
              r.med_ok = (md < 2 * cfg[wtm_pkg::CFG_MED_LIM]);
            end
            if (r.pix_ok && r.med_ok) begin
              r.matched = 1'b1;
              good = (sum << 8) / n;
              r.goodness = (good > 65535) ? 16'hFFFF : good[15:0];
            end
          end
        end
        default: ;
      endcase
      pending_q = {pending_q, r};
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(match_result_t got);
      match_result_t want;
      if (pending_q.size() == 0) begin
        $error("result transfer with no prediction pending");
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        errors++;
      end
      if (got.pix_ok !== want.pix_ok) begin
        $error("pixel_condition_ok: expected %0d, got %0d", want.pix_ok, got.pix_ok);
        errors++;
      end
      if (got.med_ok !== want.med_ok) begin
        $error("median_condition_ok: expected %0d, got %0d", want.med_ok, got.med_ok);
        errors++;
      end
      if (got.goodness !== want.goodness) begin
        $error("goodness: expected %0d, got %0d", want.goodness, got.goodness);
        errors++;
      end
      if (got.win_x !== want.win_x) begin
        $error("window_x: expected %0d, got %0d", want.win_x, got.win_x);
        errors++;
      end
      if (got.win_y !== want.win_y) begin
        $error("window_y: expected %0d, got %0d", want.win_y, got.win_y);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_operation_i = '0;
  logic [5:0]  in_row_i = '0;
  logic [5:0]  in_column_i = '0;
  logic [7:0]  in_pixel_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_status_o;
  logic        out_matched_o;
  logic        out_pixel_condition_ok_o;
  logic        out_median_condition_ok_o;
  logic [15:0] out_goodness_o;
  logic [5:0]  out_window_x_o;
  logic [5:0]  out_window_y_o;

  match_scoreboard sb = new();
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  window_template_match_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{status: out_status_o, matched: out_matched_o,
                        pix_ok: out_pixel_condition_ok_o,
                        med_ok: out_median_condition_ok_o,
                        goodness: out_goodness_o, win_x: out_window_x_o,
                        win_y: out_window_y_o});
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold off results at random
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // Drive one input transfer; returns at the falling edge after acceptance
  task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                           logic [7:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_operation_i = op;
    in_row_i = row;
    in_column_i = col;
    in_pixel_value_i = val;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, row, col, val);
    @(negedge clk_i);
  endtask

  // Drain all results so that a following register write finds the block idle
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.cfg[idx] = data;
  endtask

  task automatic set_config(logic [7:0] w, logic [7:0] h, logic [7:0] p,
                            logic [7:0] plim, logic [7:0] mlim);
    drain();
    write_reg(wtm_pkg::CFG_IMG_W, w);
    write_reg(wtm_pkg::CFG_IMG_H, h);
    write_reg(wtm_pkg::CFG_PSIZE, p);
    write_reg(wtm_pkg::CFG_PIX_LIM, plim);
    write_reg(wtm_pkg::CFG_MED_LIM, mlim);
  endtask

  function automatic logic [7:0] near_pattern(int unsigned r, int unsigned c);
    int v;
    v = int'(sb.pat[r % 16][c % 16]) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Evaluate a window inside the written area, often on a tile boundary, or one far outside if none fits
  task automatic eval_inside();
    int unsigned w, h, p, x, y;
    w = sb.size_of(wtm_pkg::CFG_IMG_W, 64);
    h = sb.size_of(wtm_pkg::CFG_IMG_H, 64);
    p = sb.size_of(wtm_pkg::CFG_PSIZE, 16);
    if (w > FILL_SIZE) w = FILL_SIZE;
    if (h > FILL_SIZE) h = FILL_SIZE;
    if (p > w || p > h) begin
      // window cannot fit: send it far outside the image
      send_item(wtm_pkg::OP_EVAL, 6'd63, 6'd63, 8'($urandom));
      return;
    end
    x = $urandom_range(0, w - p);
    y = $urandom_range(0, h - p);
    if ($urandom_range(0, 1) == 1) begin
      x = (x / 4) * 4;
      y = (y / 4) * 4;
    end
    send_item(wtm_pkg::OP_EVAL, 6'(y), 6'(x), 8'($urandom));
  endtask

  task automatic random_item();
    int unsigned r, w, h, p, rr, cc;
    r = $urandom_range(0, 99);
    w = sb.size_of(wtm_pkg::CFG_IMG_W, 64);
    h = sb.size_of(wtm_pkg::CFG_IMG_H, 64);
    p = sb.size_of(wtm_pkg::CFG_PSIZE, 16);
    rr = $urandom_range(0, 63);
    cc = $urandom_range(0, 63);
    if (r < 45) begin
      eval_inside();
    end else if (r < 55) begin
      // an accepted window must stay inside the written area
      if (cc + p <= w && rr + p <= h && (cc + p > FILL_SIZE || rr + p > FILL_SIZE))
        eval_inside();
      else
        send_item(wtm_pkg::OP_EVAL, 6'(rr), 6'(cc), 8'($urandom));
    end else if (r < 80) begin
      send_item(wtm_pkg::OP_WR_IMG, 6'(rr), 6'(cc),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : near_pattern(rr, cc));
    end else if (r < 95) begin
      // keep pattern writes mostly inside the pattern in use
      if ($urandom_range(0, 3) != 0) begin
        rr = $urandom_range(0, p - 1);
        cc = $urandom_range(0, p - 1);
      end
      send_item(wtm_pkg::OP_WR_PAT, 6'(rr), 6'(cc), 8'($urandom));
    end else begin
      send_item(OP_UNUSED, 6'(rr), 6'(cc), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] phase_cfg [6][5];
    phase_cfg = '{'{8'd64, 8'd64, 8'd4, 8'd40, 8'd20},
                  '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255},
                  '{8'd255, 8'd255, 8'd31, 8'd255, 8'd255},
                  '{8'd64, 8'd64, 8'd16, 8'd12, 8'd4},
                  '{8'd37, 8'd21, 8'd5, 8'd8, 8'd2},
                  '{8'd1, 8'd64, 8'd1, 8'd0, 8'd0}};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the pattern and the top-left image area that evaluations use
    quiet = 1'b1;
    write_reg(wtm_pkg::CFG_PSIZE, 8'd16);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_item(wtm_pkg::OP_WR_PAT, 6'(r), 6'(c), 8'($urandom));
    for (int r = 0; r < FILL_SIZE; r++)
      for (int c = 0; c < FILL_SIZE; c++)
        send_item(wtm_pkg::OP_WR_IMG, 6'(r), 6'(c), near_pattern(r, c));
    quiet = 1'b0;

    // Directed: reset settings, edges of the image and pattern, unused operation
    set_config(8'd64, 8'd64, 8'd4, 8'd10, 8'd3);
    send_item(wtm_pkg::OP_EVAL, 6'd0, 6'd0, 8'hFF);
    send_item(wtm_pkg::OP_EVAL, 6'd12, 6'd12, 8'h00);
    send_item(wtm_pkg::OP_EVAL, 6'd61, 6'd0, 8'h00);
    send_item(wtm_pkg::OP_EVAL, 6'd63, 6'd63, 8'h00);
    send_item(OP_UNUSED, 6'd63, 6'd63, 8'hFF);
    send_item(wtm_pkg::OP_WR_PAT, 6'd4, 6'd0, 8'hAA);
    send_item(wtm_pkg::OP_WR_PAT, 6'd63, 6'd63, 8'h55);
    send_item(wtm_pkg::OP_WR_PAT, 6'd3, 6'd3, 8'd0);
    send_item(wtm_pkg::OP_WR_IMG, 6'd63, 6'd63, 8'hFF);
    send_item(wtm_pkg::OP_WR_IMG, 6'd63, 6'd62, 8'h00);
    send_item(wtm_pkg::OP_EVAL, 6'd0, 6'd0, 8'h00);
    send_item(wtm_pkg::OP_EVAL, 6'd8, 6'd12, 8'h00);
    // limits of zero never match; wide limits nearly always do
    set_config(8'd64, 8'd64, 8'd4, 8'd0, 8'd3);
    send_item(wtm_pkg::OP_EVAL, 6'd0, 6'd0, 8'h00);
    set_config(8'd64, 8'd64, 8'd4, 8'd255, 8'd0);
    send_item(wtm_pkg::OP_EVAL, 6'd0, 6'd0, 8'h00);
    set_config(8'd64, 8'd64, 8'd16, 8'd255, 8'd255);
    send_item(wtm_pkg::OP_EVAL, 6'd0, 6'd0, 8'h00);
    send_item(wtm_pkg::OP_EVAL, 6'd49, 6'd48, 8'h00);
    set_config(8'd10, 8'd12, 8'd0, 8'd255, 8'd255);
    send_item(wtm_pkg::OP_WR_IMG, 6'd11, 6'd9, 8'd7);
    send_item(wtm_pkg::OP_WR_IMG, 6'd12, 6'd9, 8'd7);
    send_item(wtm_pkg::OP_WR_IMG, 6'd11, 6'd10, 8'd7);
    send_item(wtm_pkg::OP_EVAL, 6'd11, 6'd9, 8'h00);

    // Random phases, each under its own register settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6)
        set_config(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2],
                   phase_cfg[ph][3], phase_cfg[ph][4]);
      else
        set_config(8'($urandom_range(16, 64)), 8'($urandom_range(16, 64)),
                   8'($urandom_range(1, 16)), 8'($urandom_range(4, 60)),
                   8'($urandom_range(1, 30)));
      quiet = (ph == 3);
      repeat (12) random_item();
      quiet = 1'b0;
    end

    // Drain and report
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/wtm_pkg.sv
rtl/wtm_hist.sv
rtl/wtm_div.sv
rtl/window_template_match_top.sv
tb/window_template_match_top_test.sv
